>>> hw/rtl/uvst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_pkg
// shared types, constants and helpers for the uv sphere tessellator
// ----------------------------------------------------------------------------
package uvst_pkg;

   localparam int DIV_QW = 34;
   localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   localparam logic [1:0] CSR_RADIUS  = 2'd0;
   localparam logic [1:0] CSR_SECTORS = 2'd1;
   localparam logic [1:0] CSR_STACKS  = 2'd2;

   localparam logic MODE_VERTEX   = 1'b0;
   localparam logic MODE_TRIANGLE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic        up;
      logic        dn;
      logic [16:0] k1;
      logic [16:0] k2;
   } side_type;

   typedef struct packed {
      side_type   side;
      logic [8:0] stk;
      logic [8:0] sec;
   } item_type;

   typedef struct packed {
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [16:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
   } vert_type;

   typedef struct packed {
      logic phase;
      logic z_valid;
   } back_stat_type;

   function automatic logic [31:0] atan_q30(input int k);
      logic [31:0] a;
      case (k)
         0:  a = 32'h3243F6A8;
         1:  a = 32'h1DAC6705;
         2:  a = 32'h0FADBAFC;
         3:  a = 32'h07F56EA6;
         4:  a = 32'h03FEAB76;
         5:  a = 32'h01FFD55B;
         6:  a = 32'h00FFFAAA;
         7:  a = 32'h007FFF55;
         8:  a = 32'h003FFFEA;
         9:  a = 32'h001FFFFD;
         10: a = 32'h000FFFFF;
         11: a = 32'h0007FFFF;
         12: a = 32'h0003FFFF;
         13: a = 32'h0001FFFF;
         14: a = 32'h0000FFFF;
         15: a = 32'h00007FFF;
         16: a = 32'h00003FFF;
         17: a = 32'h00001FFF;
         18: a = 32'h00000FFF;
         19: a = 32'h000007FF;
         20: a = 32'h000003FF;
         21: a = 32'h000001FF;
         22: a = 32'h000000FF;
         23: a = 32'h0000007F;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

   // round half up, then arithmetic shift
   function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                    input int n);
      logic signed [63:0] h;
      h = 64'sd1 <<< (n - 1);
      return (v + h) >>> n;
   endfunction

   function automatic logic signed [16:0] sat17(input logic signed [63:0] v);
      logic signed [16:0] r;
      if (v > 64'sd65535) begin
         r = 17'sd65535;
      end else if (v < -64'sd65535) begin
         r = -17'sd65535;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd16384) begin
         r = 16'sd16384;
      end else if (v < -64'sd16384) begin
         r = -16'sd16384;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/uvst_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_div
// pipelined restoring divider, floor(num * 2^33 / den), one quotient bit a stage
// ----------------------------------------------------------------------------
module uvst_div (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [8:0]                    num,
   input  wire logic [8:0]                    den,
   output logic      [uvst_pkg::DIV_QW-1:0]   quo
);

   localparam int QW = uvst_pkg::DIV_QW;

   logic [8:0]    rem_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic          ge0;

   assign ge0 = (num >= den);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= ge0 ? (num - den) : num;
         quo_ff[0] <= QW'(ge0) << (QW - 1);
      end
   end

   for (genvar k = 1; k < QW; k++) begin : g_stage
      logic [9:0] r2;
      logic       ge;
      always_comb begin
         r2 = {rem_ff[k-1], 1'b0};
         ge = (r2 >= {1'b0, den});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? 9'(r2 - {1'b0, den}) : r2[8:0];
            quo_ff[k] <= quo_ff[k-1] | (QW'(ge) << (QW - 1 - k));
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule
`default_nettype wire

>>> hw/rtl/uvst_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_cordic
// pipelined rotation cordic, binary angle in, q30 cosine and sine out
// ----------------------------------------------------------------------------
module uvst_cordic #(
   parameter int STEPS = 16
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [31:0]        angle,
   output logic signed [31:0]      cos_out,
   output logic signed [31:0]      sin_out
);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   logic signed [33:0] x_ff [STEPS+1];
   logic signed [33:0] y_ff [STEPS+1];
   logic signed [33:0] z_ff [STEPS+1];
   logic [1:0]         q_ff [STEPS+1];
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;

   logic [60:0] zprod;
   logic [60:0] zsum;

   always_comb begin
      zprod = 61'(angle[29:0]) * 61'(uvst_pkg::HALF_PI_Q30);
      zsum  = zprod + 61'(64'd1 << 29);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= 34'(uvst_pkg::CORDIC_GAIN);
         y_ff[0] <= '0;
         z_ff[0] <= 34'(zsum[60:30]);
         q_ff[0] <= angle[31:30];
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam logic signed [33:0] ATAN_K = 34'(uvst_pkg::atan_q30(k - 1));
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[k] <= q_ff[k-1];
            if (z_ff[k-1] >= 0) begin
               x_ff[k] <= x_ff[k-1] - (y_ff[k-1] >>> (k - 1));
               y_ff[k] <= y_ff[k-1] + (x_ff[k-1] >>> (k - 1));
               z_ff[k] <= z_ff[k-1] - ATAN_K;
            end else begin
               x_ff[k] <= x_ff[k-1] + (y_ff[k-1] >>> (k - 1));
               y_ff[k] <= y_ff[k-1] - (x_ff[k-1] >>> (k - 1));
               z_ff[k] <= z_ff[k-1] + ATAN_K;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         case (q_ff[STEPS])
            QUAD_0: begin
               cos_ff <= 32'(x_ff[STEPS]);
               sin_ff <= 32'(y_ff[STEPS]);
            end
            QUAD_1: begin
               cos_ff <= 32'(-y_ff[STEPS]);
               sin_ff <= 32'(x_ff[STEPS]);
            end
            QUAD_2: begin
               cos_ff <= 32'(-x_ff[STEPS]);
               sin_ff <= 32'(-y_ff[STEPS]);
            end
            default: begin
               cos_ff <= 32'(y_ff[STEPS]);
               sin_ff <= 32'(-x_ff[STEPS]);
            end
         endcase
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
`default_nettype wire

>>> hw/rtl/uvst_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_front
// request intake: range check, drop of empty requests, triangle corner indexes
// ----------------------------------------------------------------------------
module uvst_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [8:0]           sec_cnt,
   input  wire logic [8:0]           stk_cnt,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [23:0]          req_tdata,
   input  wire logic                 req_tuser,
   output logic                      out_valid,
   output uvst_pkg::item_type        out_item,
   input  wire logic                 out_ready
);

   logic               valid_ff;
   logic               valid_in;
   uvst_pkg::item_type item_ff;
   uvst_pkg::item_type item_in;
   logic [8:0]         stk;
   logic [8:0]         sec;
   logic [19:0]        k1_full;
   logic               keep;

   assign stk = req_tdata[8:0];
   assign sec = req_tdata[17:9];
   assign req_tready = !valid_ff || out_ready;

   always_comb begin
      k1_full = 20'(stk * ({1'b0, sec_cnt} + 10'd1)) + 20'(sec);
      item_in.stk = stk;
      item_in.sec = sec;
      item_in.side.mode = req_tuser;
      item_in.side.up = (stk != '0);
      item_in.side.dn = (stk != 9'(stk_cnt - 9'd1));
      item_in.side.k1 = k1_full[16:0];
      item_in.side.k2 = 17'(k1_full + 20'(sec_cnt) + 20'd1);
      if (req_tuser == uvst_pkg::MODE_VERTEX) begin
         keep = (stk <= stk_cnt) && (sec <= sec_cnt);
      end else begin
         keep = (stk < stk_cnt) && (sec < sec_cnt) &&
                (item_in.side.up || item_in.side.dn);
      end
      if (req_tvalid && req_tready) begin
         valid_in = keep;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

>>> hw/rtl/uvst_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_fifo
// short request queue between intake and the arithmetic pipeline
// ----------------------------------------------------------------------------
module uvst_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire uvst_pkg::item_type   in_item,
   output logic                      out_valid,
   output uvst_pkg::item_type        out_item,
   input  wire logic                 out_pop
);

   localparam int DEPTH = 4;
   localparam int AW = $clog2(DEPTH);

   uvst_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0]      wr_ff;
   logic [AW-1:0]      rd_ff;
   logic [AW:0]        cnt_ff;
   logic               push;
   logic               pop;

   assign in_ready  = (cnt_ff != (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_item  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/uvst_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uvst_back
// arithmetic pipeline (dividers, cordic, scaling) and response expansion
// ----------------------------------------------------------------------------
module uvst_back #(
   parameter int STEPS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [15:0]          radius,
   input  wire logic [8:0]           sec_cnt,
   input  wire logic [8:0]           stk_cnt,
   input  wire logic                 in_valid,
   input  wire uvst_pkg::item_type   in_item,
   output logic                      in_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [183:0]              rsp_tdata,
   output logic                      rsp_tlast,
   output uvst_pkg::back_stat_type   stat
);

   localparam int DL = uvst_pkg::DIV_QW;
   localparam int CL = STEPS + 2;

   logic en;

   // divider section
   logic [DL-1:0]      qv;
   logic [DL-1:0]      qu;
   logic               dv_ff [DL];
   uvst_pkg::side_type ds_ff [DL];

   uvst_div u_div_v (.clock(clock), .en(en), .num(in_item.sec), .den(sec_cnt), .quo(qv));
   uvst_div u_div_u (.clock(clock), .en(en), .num(in_item.stk), .den(stk_cnt), .quo(qu));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DL; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (en) begin
         dv_ff[0] <= in_valid;
         for (int k = 1; k < DL; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ds_ff[0] <= in_item.side;
         for (int k = 1; k < DL; k++) begin
            ds_ff[k] <= ds_ff[k-1];
         end
      end
   end

   // angle and texture stage
   logic               p_valid_ff;
   uvst_pkg::side_type p_side_ff;
   logic [31:0]        av_ff;
   logic [31:0]        au_ff;
   logic [16:0]        pu_ff;
   logic [16:0]        pv_ff;
   logic [34:0]        qv_inc;
   logic [33:0]        qu_inc;
   logic [18:0]        tu_inc;
   logic [18:0]        tv_inc;

   always_comb begin
      qv_inc = 35'(qv) + 35'd1;
      qu_inc = 34'(qu[DL-1:1]) + 34'd1;
      tu_inc = 19'(qv[DL-1:16]) + 19'd1;
      tv_inc = 19'(qu[DL-1:16]) + 19'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= dv_ff[DL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_side_ff <= ds_ff[DL-1];
         av_ff     <= qv_inc[32:1];
         au_ff     <= 32'h4000_0000 - qu_inc[32:1];
         pu_ff     <= tu_inc[17:1];
         pv_ff     <= tv_inc[17:1];
      end
   end

   // cordic section
   logic signed [31:0] cu;
   logic signed [31:0] su;
   logic signed [31:0] cv;
   logic signed [31:0] sv;
   logic               cvl_ff [CL];
   uvst_pkg::side_type csd_ff [CL];
   logic [16:0]        ctu_ff [CL];
   logic [16:0]        ctv_ff [CL];

   uvst_cordic #(.STEPS(STEPS)) u_cordic_u (
      .clock(clock), .en(en), .angle(au_ff), .cos_out(cu), .sin_out(su)
   );
   uvst_cordic #(.STEPS(STEPS)) u_cordic_v (
      .clock(clock), .en(en), .angle(av_ff), .cos_out(cv), .sin_out(sv)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CL; k++) begin
            cvl_ff[k] <= 1'b0;
         end
      end else if (en) begin
         cvl_ff[0] <= p_valid_ff;
         for (int k = 1; k < CL; k++) begin
            cvl_ff[k] <= cvl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         csd_ff[0] <= p_side_ff;
         ctu_ff[0] <= pu_ff;
         ctv_ff[0] <= pv_ff;
         for (int k = 1; k < CL; k++) begin
            csd_ff[k] <= csd_ff[k-1];
            ctu_ff[k] <= ctu_ff[k-1];
            ctv_ff[k] <= ctv_ff[k-1];
         end
      end
   end

   // scaling stages
   logic               a_valid_ff;
   uvst_pkg::side_type a_side_ff;
   logic [16:0]        a_tu_ff;
   logic [16:0]        a_tv_ff;
   logic signed [48:0] a_xyp_ff;
   logic signed [48:0] a_zp_ff;
   logic signed [63:0] a_ncx_ff;
   logic signed [63:0] a_ncy_ff;
   logic signed [31:0] a_cv_ff;
   logic signed [31:0] a_sv_ff;
   logic signed [31:0] a_su_ff;
   logic signed [16:0] rad_s;

   assign rad_s = signed'({1'b0, radius});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= cvl_ff[CL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= csd_ff[CL-1];
         a_tu_ff   <= ctu_ff[CL-1];
         a_tv_ff   <= ctv_ff[CL-1];
         a_xyp_ff  <= rad_s * cu;
         a_zp_ff   <= rad_s * su;
         a_ncx_ff  <= cu * cv;
         a_ncy_ff  <= cu * sv;
         a_cv_ff   <= cv;
         a_sv_ff   <= sv;
         a_su_ff   <= su;
      end
   end

   logic               b_valid_ff;
   uvst_pkg::side_type b_side_ff;
   logic [16:0]        b_tu_ff;
   logic [16:0]        b_tv_ff;
   logic signed [27:0] b_xyq_ff;
   logic signed [16:0] b_pz_ff;
   logic signed [15:0] b_nx_ff;
   logic signed [15:0] b_ny_ff;
   logic signed [15:0] b_nz_ff;
   logic signed [31:0] b_cv_ff;
   logic signed [31:0] b_sv_ff;
   logic signed [63:0] xyq_full;

   assign xyq_full = uvst_pkg::round_shr(64'(a_xyp_ff), 22);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_side_ff <= a_side_ff;
         b_tu_ff   <= a_tu_ff;
         b_tv_ff   <= a_tv_ff;
         b_xyq_ff  <= 28'(xyq_full);
         b_pz_ff   <= uvst_pkg::sat17(uvst_pkg::round_shr(64'(a_zp_ff), 30));
         b_nx_ff   <= uvst_pkg::sat16(uvst_pkg::round_shr(a_ncx_ff, 46));
         b_ny_ff   <= uvst_pkg::sat16(uvst_pkg::round_shr(a_ncy_ff, 46));
         b_nz_ff   <= uvst_pkg::sat16(uvst_pkg::round_shr(64'(a_su_ff), 16));
         b_cv_ff   <= a_cv_ff;
         b_sv_ff   <= a_sv_ff;
      end
   end

   logic               c_valid_ff;
   uvst_pkg::side_type c_side_ff;
   logic [16:0]        c_tu_ff;
   logic [16:0]        c_tv_ff;
   logic signed [59:0] c_pxp_ff;
   logic signed [59:0] c_pyp_ff;
   logic signed [16:0] c_pz_ff;
   logic signed [15:0] c_nx_ff;
   logic signed [15:0] c_ny_ff;
   logic signed [15:0] c_nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_side_ff <= b_side_ff;
         c_tu_ff   <= b_tu_ff;
         c_tv_ff   <= b_tv_ff;
         c_pxp_ff  <= b_xyq_ff * b_cv_ff;
         c_pyp_ff  <= b_xyq_ff * b_sv_ff;
         c_pz_ff   <= b_pz_ff;
         c_nx_ff   <= b_nx_ff;
         c_ny_ff   <= b_ny_ff;
         c_nz_ff   <= b_nz_ff;
      end
   end

   logic               z_valid_ff;
   uvst_pkg::side_type z_side_ff;
   uvst_pkg::vert_type z_vert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         z_valid_ff <= 1'b0;
      end else if (en) begin
         z_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_side_ff        <= c_side_ff;
         z_vert_ff.pos_x  <= uvst_pkg::sat17(uvst_pkg::round_shr(64'(c_pxp_ff), 38));
         z_vert_ff.pos_y  <= uvst_pkg::sat17(uvst_pkg::round_shr(64'(c_pyp_ff), 38));
         z_vert_ff.pos_z  <= c_pz_ff;
         z_vert_ff.norm_x <= c_nx_ff;
         z_vert_ff.norm_y <= c_ny_ff;
         z_vert_ff.norm_z <= c_nz_ff;
         z_vert_ff.tex_u  <= c_tu_ff;
         z_vert_ff.tex_v  <= c_tv_ff;
      end
   end

   // response expansion: a cell may give two triangles
   logic               phase_ff;
   logic               phase_in;
   logic               rv_ff;
   logic               rv_in;
   logic [183:0]       rd_ff;
   logic               rl_ff;
   logic               take;
   logic               two;
   logic               pop;
   logic               use_up;
   logic [16:0]        ca;
   logic [16:0]        cb;
   logic [16:0]        cc;
   uvst_pkg::vert_type ev;
   logic [183:0]       emit_data;
   logic               emit_last;

   always_comb begin
      take   = !rv_ff || rsp_tready;
      two    = (z_side_ff.mode == uvst_pkg::MODE_TRIANGLE) && z_side_ff.up && z_side_ff.dn;
      pop    = z_valid_ff && take && !(two && !phase_ff);
      en     = !z_valid_ff || pop;
      use_up = z_side_ff.up && !phase_ff;
      if (z_side_ff.mode == uvst_pkg::MODE_VERTEX) begin
         ev = z_vert_ff;
         ca = '0;
         cb = '0;
         cc = '0;
         emit_last = 1'b1;
      end else begin
         ev = '0;
         cb = z_side_ff.k2;
         if (use_up) begin
            ca = z_side_ff.k1;
            cc = z_side_ff.k1 + 17'd1;
         end else begin
            ca = z_side_ff.k1 + 17'd1;
            cc = z_side_ff.k2 + 17'd1;
         end
         emit_last = !(two && !phase_ff);
      end
      emit_data = {cc, cb, ca, ev.tex_v, ev.tex_u, ev.norm_z, ev.norm_y, ev.norm_x,
                   ev.pos_z, ev.pos_y, ev.pos_x};
      if (z_valid_ff && take) begin
         rv_in    = 1'b1;
         phase_in = two && !phase_ff;
      end else begin
         rv_in    = rv_ff && !rsp_tready;
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (z_valid_ff && take) begin
         rd_ff <= emit_data;
         rl_ff <= emit_last;
      end
   end

   assign in_pop       = en && in_valid;
   assign rsp_tvalid   = rv_ff;
   assign rsp_tdata    = rd_ff;
   assign rsp_tlast    = rl_ff;
   assign stat.phase   = phase_ff;
   assign stat.z_valid = z_valid_ff;

endmodule
`default_nettype wire

>>> hw/rtl/uv_sphere_tessellator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_tessellator
// uv sphere mesh generator: vertex records and index triangles per request
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: stack, sector; tuser: mode
//   rsp      out  rsp_tvalid/rsp_tready  tdata: vertex and corner fields; tlast
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// one request per cycle enters while the queue has room; a cell with two
// triangles holds the pipeline while its second triangle is sent. a request
// passes 34 divider stages, the angle stage, the cordic and scaling stages.
// reset is synchronous and needs no clearing pass. a stalled response freezes
// the arithmetic pipeline once its last stage holds a cell; requests keep being
// taken until the intake register and the four queue entries are full.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator #(
   parameter int MAX_SECTORS  = 256,
   parameter int MAX_STACKS   = 256,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [23:0]   req_tdata,   // stack_index[8:0], sector_index[17:9]
   input  wire logic          req_tuser,   // mode
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [183:0]       rsp_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y,
                                           // norm_z, tex_u, tex_v, corner_a,
                                           // corner_b, corner_c
   output logic               rsp_tlast,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_data
);

   logic [15:0] radius_ff;
   logic [8:0]  sector_count_ff;
   logic [8:0]  stack_count_ff;
   logic [8:0]  sec_eff;
   logic [8:0]  stk_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff       <= 16'd256;
         sector_count_ff <= 9'd16;
         stack_count_ff  <= 9'd8;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            uvst_pkg::CSR_RADIUS:  radius_ff       <= csr_data;
            uvst_pkg::CSR_SECTORS: sector_count_ff <= csr_data[8:0];
            uvst_pkg::CSR_STACKS:  stack_count_ff  <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (sector_count_ff == '0) begin
         sec_eff = 9'd1;
      end else if (32'(sector_count_ff) > MAX_SECTORS) begin
         sec_eff = 9'(MAX_SECTORS);
      end else begin
         sec_eff = sector_count_ff;
      end
      if (stack_count_ff == '0) begin
         stk_eff = 9'd1;
      end else if (32'(stack_count_ff) > MAX_STACKS) begin
         stk_eff = 9'(MAX_STACKS);
      end else begin
         stk_eff = stack_count_ff;
      end
   end

   logic                    f_valid;
   logic                    f_ready;
   uvst_pkg::item_type      f_item;
   logic                    q_valid;
   uvst_pkg::item_type      q_item;
   logic                    q_pop;
   uvst_pkg::back_stat_type stat;

   uvst_front u_front (
      .clock(clock), .reset(reset), .sec_cnt(sec_eff), .stk_cnt(stk_eff),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .out_valid(f_valid), .out_item(f_item),
      .out_ready(f_ready)
   );

   uvst_fifo u_fifo (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready),
      .in_item(f_item), .out_valid(q_valid), .out_item(q_item), .out_pop(q_pop)
   );

   uvst_back #(.STEPS(CORDIC_STEPS)) u_back (
      .clock(clock), .reset(reset), .radius(radius_ff), .sec_cnt(sec_eff),
      .stk_cnt(stk_eff), .in_valid(q_valid), .in_item(q_item), .in_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .stat(stat)
   );

`ifndef SYNTH
   a_phase_has_item: assert property (@(posedge clock) disable iff (reset)
      stat.phase |-> stat.z_valid)
      else $error("second triangle pending without a held cell");

   a_phase_first_not_last: assert property (@(posedge clock) disable iff (reset)
      stat.phase |-> (rsp_tvalid && !rsp_tlast))
      else $error("first triangle of a pair marked last");

   a_pair_second_last: assert property (@(posedge clock) disable iff (reset)
      (stat.phase && rsp_tready) |=> (rsp_tvalid && rsp_tlast))
      else $error("second triangle of a pair not marked last");
`endif

endmodule
`default_nettype wire
